// ===== rtl/core/gle_pkg.sv =====
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types and constants of the gray Laplacian edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gle_pkg;

	// line buffer depth and column range
	localparam int GLE_MAX_WIDTH = 1024;

	// configuration port
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd512;
	localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd512;

	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

	// payload widths
	localparam int PIX_W   = 8;
	localparam int OUT_X_W = 10;
	localparam int ROW_W   = 12;

	// luma weights, q16, they sum to 65536
	localparam int          PROD_W = 24;
	localparam logic [15:0] COEF_R = 16'd19595;
	localparam logic [15:0] COEF_G = 16'd38470;
	localparam logic [15:0] COEF_B = 16'd7471;

	// one column of the 3x3 window, top is two rows above
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} gle_col_t;

endpackage

`default_nettype wire

// ===== rtl/core/gray_laplacian_edge_filter_unit.sv =====
// ----------------------------------------------------------------------------
// gray_laplacian_edge_filter_unit
// RGB to gray conversion and 3x3 Laplacian edge response over a raster stream.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order unless stalled, converts it to
// 8-bit gray and runs it through two line buffers and a window of three column
// cells. For every interior pixel it delivers 255 minus the clamped Laplacian
// response with the pixel's coordinates; border pixels give no result.
// Sustained rate is one pixel per clock without output stalls, set by the
// single read and write per line buffer per pixel. Pixel (x, y) yields the
// result for centre (x-1, y-1) via stage 1, window cells and output register.
// No clearing pass after reset: line buffers only feed results where this
// frame wrote them. Write the size registers only while the block is idle.
`default_nettype none

module gray_laplacian_edge_filter_unit import gle_pkg::*; #(
	parameter int MAX_WIDTH = GLE_MAX_WIDTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	// pixel input
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [PIX_W-1:0]        red,
	input  wire logic [PIX_W-1:0]        green,
	input  wire logic [PIX_W-1:0]        blue,
	input  wire logic                    frame_start,
	// result output
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [PIX_W-1:0]             edge_value,
	output logic [OUT_X_W-1:0]           out_x,
	output logic [ROW_W-1:0]             out_y,
	output logic                         frame_last
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
	localparam logic [WCW-1:0] W_MIN = WCW'(3);
	localparam logic [WCW-1:0] W_MAX = WCW'(MAX_WIDTH);

	// configuration registers
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RESET;
			height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[CFG_WIDTH_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[CFG_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	logic [WCW-1:0]          w_eff;
	logic [CFG_HEIGHT_W-1:0] h_eff;

	always_comb begin
		if (WCW'(width_q) < W_MIN) begin
			w_eff = W_MIN;
		end else if (WCW'(width_q) > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = WCW'(width_q);
		end
		if (height_q < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else if (height_q > HEIGHT_MAX) begin
			h_eff = HEIGHT_MAX;
		end else begin
			h_eff = height_q;
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, out_valid_q;
	logic out_free, s2_go, s1_adv, accept;

	assign out_free = !out_valid_q || out_ready;
	assign s2_go    = !v_s2 || out_free;
	assign s1_adv   = v_s1 && s2_go;
	assign in_ready = !v_s1 || s2_go;
	assign accept   = in_valid && in_ready;

	// position of the incoming pixel
	logic [CW-1:0]           col_q;
	logic [ROW_W-1:0]        row_q;
	logic [CW-1:0]           x_in;
	logic [ROW_W-1:0]        y_in;
	logic [CFG_HEIGHT_W-1:0] y_next;
	logic                    col_last, row_last;

	assign x_in     = frame_start ? '0 : col_q;
	assign y_in     = frame_start ? '0 : row_q;
	assign y_next   = CFG_HEIGHT_W'(y_in) + CFG_HEIGHT_W'(1);
	assign col_last = (WCW'(x_in) + WCW'(1)) >= w_eff;
	assign row_last = y_next >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : y_next[ROW_W-1:0];
			end else begin
				col_q <= x_in + CW'(1);
				row_q <= y_in;
			end
		end
	end

	// stage 1: products, line buffer read in flight
	logic [CW-1:0]      x_s1;
	logic [PROD_W-1:0]  prod_r_s1, prod_g_s1, prod_b_s1;
	logic               byp_s1, res_s1, last_s1;
	logic [PIX_W-1:0]   fwd_above_s1, fwd_two_s1;
	logic [OUT_X_W-1:0] ox_s1;
	logic [ROW_W-1:0]   oy_s1;

	logic [PROD_W-1:0]  luma_sum;
	logic [PIX_W-1:0]   gray_s1, above_s1, two_s1;
	logic [PIX_W-1:0]   rd_above, rd_two;

	assign luma_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign gray_s1  = luma_sum[PROD_W-1 -: PIX_W];
	assign above_s1 = byp_s1 ? fwd_above_s1 : rd_above;
	assign two_s1   = byp_s1 ? fwd_two_s1 : rd_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1      <= x_in;
			prod_r_s1 <= PROD_W'(COEF_R) * PROD_W'(red);
			prod_g_s1 <= PROD_W'(COEF_G) * PROD_W'(green);
			prod_b_s1 <= PROD_W'(COEF_B) * PROD_W'(blue);
			// same column written this cycle by the item leaving stage 1
			byp_s1       <= s1_adv && (x_s1 == x_in);
			fwd_above_s1 <= gray_s1;
			fwd_two_s1   <= above_s1;
			res_s1       <= (x_in >= CW'(2)) && (y_in >= ROW_W'(2));
			last_s1      <= col_last && row_last;
			ox_s1        <= OUT_X_W'(x_in - CW'(1));
			oy_s1        <= y_in - ROW_W'(1);
		end
	end

	gle_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_above (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (x_s1),
		.wdata (gray_s1),
		.re    (accept),
		.raddr (x_in),
		.rdata (rd_above)
	);

	gle_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_two_above (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (x_s1),
		.wdata (above_s1),
		.re    (accept),
		.raddr (x_in),
		.rdata (rd_two)
	);

	// window: cell 2 takes the new column, older columns move toward cell 0
	gle_col_t   cell_in  [3];
	gle_col_t   cell_out [3];
	logic [9:0] cell_sum [3];

	assign cell_in[2] = '{top: two_s1, mid: above_s1, bot: gray_s1};
	assign cell_in[1] = cell_out[2];
	assign cell_in[0] = cell_out[1];

	for (genvar i = 0; i < 3; i++) begin : g_cell
		gle_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (s1_adv),
			.col_in  (cell_in[i]),
			.col_out (cell_out[i]),
			.col_sum (cell_sum[i])
		);
	end

	// stage 2: window is current, compute the response
	logic [OUT_X_W-1:0] ox_s2;
	logic [ROW_W-1:0]   oy_s2;
	logic               last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_go) begin
			v_s2 <= s1_adv && res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ox_s2   <= ox_s1;
			oy_s2   <= oy_s1;
			last_s2 <= last_s1;
		end
	end

	logic [11:0]       sum_all, nine_c;
	logic signed [12:0] lap;
	logic [PIX_W-1:0]  lap_clamped, edge_s2;

	assign sum_all = 12'(cell_sum[0]) + 12'(cell_sum[1]) + 12'(cell_sum[2]);
	assign nine_c  = {1'b0, cell_out[1].mid, 3'b000} + 12'(cell_out[1].mid);
	assign lap     = $signed({1'b0, sum_all}) - $signed({1'b0, nine_c});

	always_comb begin
		if (lap < 0) begin
			lap_clamped = '0;
		end else if (lap > 13'sd255) begin
			lap_clamped = 8'd255;
		end else begin
			lap_clamped = lap[PIX_W-1:0];
		end
	end

	assign edge_s2 = 8'd255 - lap_clamped;

	// output register
	logic [PIX_W-1:0]   edge_q;
	logic [OUT_X_W-1:0] out_x_q;
	logic [ROW_W-1:0]   out_y_q;
	logic               frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s2) begin
			edge_q       <= edge_s2;
			out_x_q      <= ox_s2;
			out_y_q      <= oy_s2;
			frame_last_q <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_value = edge_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign frame_last = frame_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/gle_ram.sv =====
// ----------------------------------------------------------------------------
// gle_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gle_cell.sv =====
// ----------------------------------------------------------------------------
// gle_cell
// One column of the 3x3 window: holds three gray pixels, passes them on to
// the next cell on every shift and reports their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_cell import gle_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     shift,
	input  wire gle_col_t col_in,
	output gle_col_t      col_out,
	output logic [9:0]    col_sum
);

	gle_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign col_sum = 10'(col_q.top) + 10'(col_q.mid) + 10'(col_q.bot);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gray Laplacian edge filter: pixels go in over a
// valid/ready channel while a local line-buffer model predicts each interior
// result; results are compared in order, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import gle_pkg::*;

	localparam int unsigned LUMA_R = 19595;
	localparam int unsigned LUMA_G = 38470;
	localparam int unsigned LUMA_B = 7471;
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0]   edge_val;
		logic [OUT_X_W-1:0] x;
		logic [ROW_W-1:0]   y;
		logic               last;
	} edge_res_t;

	typedef struct packed {
		pixel_t    pix;
		logic      typed;
		edge_res_t res;
	} stim_row_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		int         wreg;
		int         hreg;
		int         count;
		bit         restart;
		bit         noise;
		bit         hold;
		bit         pause;
		idle_mode_t mode;
	} phase_t;

	localparam edge_res_t NO_EDGE = '0;
	localparam pixel_t WHITE    = '{8'd255, 8'd255, 8'd255, 1'b0};
	localparam pixel_t WHITE_FS = '{8'd255, 8'd255, 8'd255, 1'b1};
	localparam pixel_t BLACK    = '{8'd0, 8'd0, 8'd0, 1'b0};
	localparam pixel_t RED_P    = '{8'd255, 8'd0, 8'd0, 1'b0};
	localparam pixel_t GREEN_P  = '{8'd0, 8'd255, 8'd0, 1'b0};
	localparam pixel_t BLUE_P   = '{8'd0, 8'd0, 8'd255, 1'b0};

	// 3x3 frames: flat white, then a dark centre among bright neighbours,
	// then a restart in the middle of a frame
	stim_row_t directed_rows [25] = '{
		'{WHITE_FS, 1'b0, NO_EDGE}, '{WHITE, 1'b0, NO_EDGE}, '{WHITE, 1'b0, NO_EDGE},
		'{WHITE, 1'b0, NO_EDGE}, '{WHITE, 1'b0, NO_EDGE}, '{WHITE, 1'b0, NO_EDGE},
		'{WHITE, 1'b0, NO_EDGE}, '{WHITE, 1'b0, NO_EDGE},
		'{WHITE, 1'b1, '{8'd255, 10'd1, 12'd1, 1'b1}},
		'{RED_P, 1'b0, NO_EDGE}, '{GREEN_P, 1'b0, NO_EDGE}, '{BLUE_P, 1'b0, NO_EDGE},
		'{WHITE, 1'b0, NO_EDGE}, '{BLACK, 1'b0, NO_EDGE}, '{RED_P, 1'b0, NO_EDGE},
		'{GREEN_P, 1'b0, NO_EDGE}, '{BLUE_P, 1'b0, NO_EDGE},
		'{WHITE, 1'b1, '{8'd0, 10'd1, 12'd1, 1'b1}},
		'{'{8'd128, 8'd64, 8'd32, 1'b0}, 1'b0, NO_EDGE},
		'{'{8'd1, 8'd2, 8'd4, 1'b0}, 1'b0, NO_EDGE},
		'{BLACK, 1'b0, NO_EDGE},
		'{'{8'd254, 8'd253, 8'd251, 1'b1}, 1'b0, NO_EDGE},
		'{'{8'd0, 8'd255, 8'd255, 1'b0}, 1'b0, NO_EDGE},
		'{'{8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, NO_EDGE},
		'{'{8'd255, 8'd255, 8'd0, 1'b0}, 1'b0, NO_EDGE}
	};

	idle_mode_t rand_modes [6] = '{IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER,
		IDLE_BOTH, IDLE_NONE};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [PIX_W-1:0]       red = '0;
	logic [PIX_W-1:0]       green = '0;
	logic [PIX_W-1:0]       blue = '0;
	logic                   frame_start = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [PIX_W-1:0]       edge_value;
	logic [OUT_X_W-1:0]     out_x;
	logic [ROW_W-1:0]       out_y;
	logic                   frame_last;

	// predictor state
	logic [CFG_WIDTH_W-1:0]  cfg_width = IMAGE_WIDTH_RESET;
	logic [CFG_HEIGHT_W-1:0] cfg_height = IMAGE_HEIGHT_RESET;
	logic [PIX_W-1:0]        gray_row1 [GLE_MAX_WIDTH];
	logic [PIX_W-1:0]        gray_row2 [GLE_MAX_WIDTH];
	logic [PIX_W-1:0]        gray_win [9];
	int unsigned             col_pos = 0;
	int unsigned             row_pos = 0;

	edge_res_t    pending_edges [$];
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	logic [7:0]   tone = 8'd128;

	always #5 clk = ~clk;

	gray_laplacian_edge_filter_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.edge_value (edge_value),
		.out_x      (out_x),
		.out_y      (out_y),
		.frame_last (frame_last)
	);

	function automatic bit predict_edge(input pixel_t pix, output edge_res_t res);
		int unsigned w, h, x, y, gray;
		int lap;
		bit hit;
		w = (cfg_width < 3) ? 3 : ((cfg_width > GLE_MAX_WIDTH) ? GLE_MAX_WIDTH : cfg_width);
		h = (cfg_height < 3) ? 3 : ((cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_height);
		if (pix.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = (col_pos >= GLE_MAX_WIDTH) ? 0 : col_pos;
		y = row_pos;
		gray = (LUMA_R * pix.red + LUMA_G * pix.green + LUMA_B * pix.blue) >> 16;
		// window columns move left, the new column enters on the right
		for (int k = 0; k < 3; k++) begin
			gray_win[k*3]   = gray_win[k*3+1];
			gray_win[k*3+1] = gray_win[k*3+2];
		end
		gray_win[2] = gray_row2[x];
		gray_win[5] = gray_row1[x];
		gray_win[8] = gray[7:0];
		gray_row2[x] = gray_row1[x];
		gray_row1[x] = gray[7:0];
		hit = (x >= 2 && y >= 2);
		res = '0;
		if (hit) begin
			lap = 0;
			for (int k = 0; k < 9; k++)
				lap += int'(gray_win[k]);
			lap -= 9 * int'(gray_win[4]);
			if (lap > 255)
				lap = 255;
			if (lap < 0)
				lap = 0;
			res.edge_val = 8'(255 - lap);
			res.x = OUT_X_W'(x - 1);
			res.y = ROW_W'(y - 1);
			res.last = (x + 1 >= w && y + 1 >= h);
		end
		if (x + 1 >= w) begin
			col_pos = 0;
			row_pos = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
			row_pos = y;
		end
		return hit;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_edges.size() != 0);
	endtask

	task automatic set_size(input int wreg, input int hreg);
		wait_drained();
		// border pixels give no result, so the pipe may still be busy
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= CFG_DATA_W'(wreg);
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= CFG_DATA_W'(hreg);
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_width  = CFG_WIDTH_W'(wreg);
		cfg_height = CFG_HEIGHT_W'(hreg);
	endtask

	task automatic push_pixel(input pixel_t pix, input bit typed, input edge_res_t typed_res);
		edge_res_t res;
		bit hit;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		red         <= pix.red;
		green       <= pix.green;
		blue        <= pix.blue;
		frame_start <= pix.frame_start;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hit = predict_edge(pix, res);
		if (typed)
			pending_edges.push_back(typed_res);
		else if (hit)
			pending_edges.push_back(res);
	endtask

	initial begin
		phase_t plan [$];
		phase_t ph;
		pixel_t pix;
		for (int i = 0; i < GLE_MAX_WIDTH; i++) begin
			gray_row1[i] = '0;
			gray_row2[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			gray_win[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register values below 3 are taken as 3
		set_size(0, 0);
		foreach (directed_rows[i])
			push_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].res);

		// second and third phases run on without restart: row cut short by a
		// narrower width, then a row count beyond a lowered height
		plan.push_back('{12, 6, 45, 1'b1, 1'b0, 1'b0, 1'b0, IDLE_NONE});
		plan.push_back('{4, 5, 19, 1'b0, 1'b0, 1'b0, 1'b0, IDLE_SENDER});
		plan.push_back('{4, 3, 60, 1'b0, 1'b0, 1'b0, 1'b0, IDLE_RECEIVER});
		plan.push_back('{2047, 3, 120, 1'b1, 1'b0, 1'b0, 1'b0, IDLE_BOTH});
		plan.push_back('{3, 8191, 150, 1'b1, 1'b1, 1'b0, 1'b0, IDLE_SENDER});
		plan.push_back('{1, 1, 90, 1'b1, 1'b1, 1'b0, 1'b0, IDLE_RECEIVER});
		plan.push_back('{1024, 4096, 40, 1'b1, 1'b0, 1'b0, 1'b0, IDLE_NONE});
		for (int i = 0; i < 6; i++)
			plan.push_back('{$urandom_range(3, 16), $urandom_range(3, 8),
				$urandom_range(40, 70), 1'b1, 1'b1, i == 0, i == 1, rand_modes[i]});

		foreach (plan[i]) begin
			ph = plan[i];
			set_size(ph.wreg, ph.hreg);
			send_idle_pct = (ph.mode == IDLE_SENDER) ? 58 : (ph.mode == IDLE_BOTH) ? 18 : 0;
			stall_pct = (ph.mode == IDLE_RECEIVER) ? 58 : (ph.mode == IDLE_BOTH) ? 18 : 0;
			if (ph.hold)
				hold_left = HOLD_CYCLES;
			tone = 8'($urandom_range(255));
			for (int n = 0; n < ph.count; n++) begin
				if (ph.pause && n == ph.count / 2)
					wait_drained();
				if ($urandom_range(99) < 35) begin
					pix.red   = 8'($urandom_range(255));
					pix.green = 8'($urandom_range(255));
					pix.blue  = 8'($urandom_range(255));
				end else begin
					// near-flat patch keeps the response away from the clamps
					if ($urandom_range(99) < 3)
						tone = 8'($urandom_range(255));
					pix.red   = (tone > 249) ? 8'(tone - $urandom_range(6)) :
						8'(tone + $urandom_range(6));
					pix.green = (tone > 249) ? 8'(tone - $urandom_range(6)) :
						8'(tone + $urandom_range(6));
					pix.blue  = (tone > 249) ? 8'(tone - $urandom_range(6)) :
						8'(tone + $urandom_range(6));
				end
				pix.frame_start = (n == 0 && ph.restart) ||
					(ph.noise && $urandom_range(199) == 0);
				push_pixel(pix, 1'b0, NO_EDGE);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side: check each transfer, then pick ready for the next cycle
	initial begin
		edge_res_t got, want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{edge_value, out_x, out_y, frame_last};
				if (pending_edges.size() == 0) begin
					$display("%0t: unexpected result edge %0d at (%0d,%0d) last %0b",
						$realtime, got.edge_val, got.x, got.y, got.last);
					mismatch_count++;
				end else begin
					want = pending_edges.pop_front();
					if (got !== want) begin
						$display("%0t: expected edge %0d at (%0d,%0d) last %0b, got edge %0d at (%0d,%0d) last %0b",
							$realtime, want.edge_val, want.x, want.y, want.last,
							got.edge_val, got.x, got.y, got.last);
						mismatch_count++;
					end
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_edges.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
